FILE: rtl/wsts_pkg.sv
// Package for the weighted sum-tree sampler: widths, action and error codes,
// step-unit structs and tree index helpers. No dependencies.
`default_nettype none

package wsts_pkg;

    localparam int MAX_NODES   = 1024;
    localparam int IDX_W       = $clog2(MAX_NODES);
    localparam int CNT_W       = IDX_W + 1;
    localparam int WEIGHT_BITS = 32;
    localparam int FRAC_W      = 32;
    localparam int TOT_W       = 42;
    localparam int HI_W        = TOT_W - FRAC_W;
    localparam int PROD_W      = 2 * FRAC_W;

    localparam logic [1:0] ACT_APPEND = 2'd0;
    localparam logic [1:0] ACT_SET    = 2'd1;
    localparam logic [1:0] ACT_SAMPLE = 2'd2;

    localparam logic [1:0] ERR_OK    = 2'd0;
    localparam logic [1:0] ERR_FULL  = 2'd1;
    localparam logic [1:0] ERR_INDEX = 2'd2;
    localparam logic [1:0] ERR_ZERO  = 2'd3;

    typedef struct packed {
        logic [TOT_W-1:0]       w;
        logic [WEIGHT_BITS-1:0] wt;
        logic [TOT_W-1:0]       tl;
        logic [TOT_W-1:0]       tr;
    } t_step_in;

    typedef struct packed {
        logic             pick;
        logic             left;
        logic [TOT_W-1:0] w_next;
        logic [TOT_W-1:0] sum;
    } t_step_out;

    function automatic logic [CNT_W-1:0] f_left(input logic [IDX_W-1:0] idx);
        f_left = {idx, 1'b1};
    endfunction

    function automatic logic [CNT_W:0] f_right(input logic [IDX_W-1:0] idx);
        f_right = {1'b0, idx, 1'b0} + (CNT_W+1)'(2);
    endfunction

endpackage

`default_nettype wire

FILE: rtl/wsts_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module wsts_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

FILE: rtl/wsts_step.sv
// Shared tree step unit: subtree total for a refresh level, and the
// compare/subtract decision for one descent level. Uses wsts_pkg.
`default_nettype none

module wsts_step (
    input  wire wsts_pkg::t_step_in  i_step,
    output      wsts_pkg::t_step_out o_step
);

    logic [wsts_pkg::TOT_W-1:0] wt_ext;
    logic [wsts_pkg::TOT_W-1:0] d1;

    always_comb begin
        wt_ext        = {{(wsts_pkg::TOT_W-wsts_pkg::WEIGHT_BITS){1'b0}}, i_step.wt};
        d1            = i_step.w - wt_ext;
        o_step.sum    = wt_ext + i_step.tl + i_step.tr;
        o_step.pick   = i_step.w < wt_ext;
        o_step.left   = d1 < i_step.tl;
        o_step.w_next = o_step.left ? d1 : d1 - i_step.tl;
    end

endmodule

`default_nettype wire

FILE: rtl/weighted_sum_tree_sampler.sv
// Top level of the weighted sum-tree sampler: sequencer, shared multiplier,
// weight and subtree-total RAMs. Uses wsts_pkg, wsts_ram, wsts_step.
//
//  channel | valid       | ready       | payload
//  in      | i_in_valid  | o_in_ready  | i_action, i_node_index, i_weight, i_uniform_point
//  out     | o_out_valid | i_out_ready | o_chosen_index, o_total_weight, o_error_code
//
// Append/set: accept, a write state, a refresh step for each tree level up to
// the root (one RAM read per level), output load. Sample: accept, multiply
// (ST_M1, ST_M2), sum and clamp (ST_M3), a descent step for each level, load.
// Errors go from accept straight to the load. Input is accepted only when idle.
// The output register frees the sequencer; a stalled output holds it in the
// final state. Reset clears node count, root total and output valid.
`default_nettype none

module weighted_sum_tree_sampler (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output      logic                          o_in_ready,
    input  wire logic [1:0]                    i_action,
    input  wire logic [wsts_pkg::IDX_W-1:0]    i_node_index,
    input  wire logic [31:0]                   i_weight,
    input  wire logic [wsts_pkg::FRAC_W-1:0]   i_uniform_point,
    output      logic                          o_out_valid,
    input  wire logic                          i_out_ready,
    output      logic [wsts_pkg::IDX_W-1:0]    o_chosen_index,
    output      logic [wsts_pkg::TOT_W-1:0]    o_total_weight,
    output      logic [1:0]                    o_error_code
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_WRT  = 3'd1;
    localparam logic [2:0] ST_REF  = 3'd2;
    localparam logic [2:0] ST_M1   = 3'd3;
    localparam logic [2:0] ST_M2   = 3'd4;
    localparam logic [2:0] ST_M3   = 3'd5;
    localparam logic [2:0] ST_DESC = 3'd6;
    localparam logic [2:0] ST_DONE = 3'd7;

    localparam int IW = wsts_pkg::IDX_W;
    localparam int CW = wsts_pkg::CNT_W;
    localparam int TW = wsts_pkg::TOT_W;
    localparam int WB = wsts_pkg::WEIGHT_BITS;
    localparam int FW = wsts_pkg::FRAC_W;

    logic [2:0]    r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [TW-1:0] r_root, n_root;
    logic          r_ovalid, n_ovalid;

    logic [IW-1:0] r_cur, n_cur;
    logic [WB-1:0] r_wt, n_wt;
    logic [FW-1:0] r_u, n_u;
    logic          r_first, n_first;
    logic [IW-1:0] r_fwd_idx, n_fwd_idx;
    logic [TW-1:0] r_fwd, n_fwd;
    logic [FW-1:0] r_lo, n_lo;
    logic [TW-1:0] r_hi, n_hi;
    logic [TW-1:0] r_w, n_w;
    logic [IW-1:0] r_chosen, n_chosen;
    logic [1:0]    r_err, n_err;
    logic [IW-1:0] r_o_chosen, n_o_chosen;
    logic [TW-1:0] r_o_total, n_o_total;
    logic [1:0]    r_o_err, n_o_err;

    logic          we_w, we_t;
    logic [IW-1:0] w_raddr, ta_raddr, tb_raddr;
    logic [WB-1:0] rd_wt;
    logic [TW-1:0] rd_ta, rd_tb;

    logic [CW-1:0] l_idx;
    logic [CW:0]   r_idx;
    logic          l_pres, rr_pres;
    logic [IW-1:0] parent;
    logic [IW-1:0] nxt;
    logic [CW-1:0] p_left, nxt_left;
    logic [CW:0]   p_right;
    logic [FW-1:0] mul_b;
    logic [wsts_pkg::PROD_W-1:0] prod;
    logic [TW:0]   w_sum;

    wsts_pkg::t_step_in  step_in;
    wsts_pkg::t_step_out step_out;

    wsts_ram #(.WIDTH(WB), .DEPTH(wsts_pkg::MAX_NODES)) u_weight_ram (
        .i_clk   (i_clk),
        .i_we    (we_w),
        .i_waddr (r_cur),
        .i_wdata (r_wt),
        .i_raddr (w_raddr),
        .o_rdata (rd_wt)
    );

    wsts_ram #(.WIDTH(TW), .DEPTH(wsts_pkg::MAX_NODES)) u_total_ram_a (
        .i_clk   (i_clk),
        .i_we    (we_t),
        .i_waddr (r_cur),
        .i_wdata (step_out.sum),
        .i_raddr (ta_raddr),
        .o_rdata (rd_ta)
    );

    wsts_ram #(.WIDTH(TW), .DEPTH(wsts_pkg::MAX_NODES)) u_total_ram_b (
        .i_clk   (i_clk),
        .i_we    (we_t),
        .i_waddr (r_cur),
        .i_wdata (step_out.sum),
        .i_raddr (tb_raddr),
        .o_rdata (rd_tb)
    );

    wsts_step u_step (
        .i_step (step_in),
        .o_step (step_out)
    );

    assign o_in_ready     = (r_state == ST_IDLE);
    assign o_out_valid    = r_ovalid;
    assign o_chosen_index = r_o_chosen;
    assign o_total_weight = r_o_total;
    assign o_error_code   = r_o_err;

    always_comb begin
        l_idx    = wsts_pkg::f_left(r_cur);
        r_idx    = wsts_pkg::f_right(r_cur);
        l_pres   = l_idx < r_count;
        rr_pres  = r_idx < {1'b0, r_count};
        parent   = (r_cur - IW'(1)) >> 1;
        p_left   = wsts_pkg::f_left(parent);
        p_right  = wsts_pkg::f_right(parent);

        step_in.w  = r_w;
        step_in.wt = r_first ? r_wt : rd_wt;
        if (!l_pres) begin
            step_in.tl = '0;
        end else if (!r_first && (l_idx == {1'b0, r_fwd_idx})) begin
            step_in.tl = r_fwd;
        end else begin
            step_in.tl = rd_ta;
        end
        if (!rr_pres) begin
            step_in.tr = '0;
        end else if (!r_first && (r_idx == {2'b00, r_fwd_idx})) begin
            step_in.tr = r_fwd;
        end else begin
            step_in.tr = rd_tb;
        end

        nxt      = step_out.left ? l_idx[IW-1:0] : r_idx[IW-1:0];
        nxt_left = wsts_pkg::f_left(nxt);

        mul_b = (r_state == ST_M1) ? r_root[FW-1:0]
                                   : {{(FW-wsts_pkg::HI_W){1'b0}}, r_root[TW-1:FW]};
        prod  = {{FW{1'b0}}, r_u} * {{FW{1'b0}}, mul_b};
        w_sum = {1'b0, r_hi} + {{(TW+1-FW){1'b0}}, r_lo};
    end

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_root     = r_root;
        n_ovalid   = r_ovalid;
        n_cur      = r_cur;
        n_wt       = r_wt;
        n_u        = r_u;
        n_first    = r_first;
        n_fwd_idx  = r_fwd_idx;
        n_fwd      = r_fwd;
        n_lo       = r_lo;
        n_hi       = r_hi;
        n_w        = r_w;
        n_chosen   = r_chosen;
        n_err      = r_err;
        n_o_chosen = r_o_chosen;
        n_o_total  = r_o_total;
        n_o_err    = r_o_err;
        we_w       = 1'b0;
        we_t       = 1'b0;
        w_raddr    = r_cur;
        ta_raddr   = l_idx[IW-1:0];
        tb_raddr   = r_idx[IW-1:0];

        if (r_ovalid && i_out_ready) begin
            n_ovalid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_chosen = '0;
                    n_err    = wsts_pkg::ERR_OK;
                    n_wt     = i_weight[WB-1:0];
                    n_u      = i_uniform_point;
                    n_first  = 1'b0;
                    n_state  = ST_DONE;
                    unique case (i_action)
                        wsts_pkg::ACT_APPEND: begin
                            if (r_count == CW'(wsts_pkg::MAX_NODES)) begin
                                n_err = wsts_pkg::ERR_FULL;
                            end else begin
                                n_cur    = r_count[IW-1:0];
                                n_chosen = r_count[IW-1:0];
                                n_count  = r_count + CW'(1);
                                n_state  = ST_WRT;
                            end
                        end
                        wsts_pkg::ACT_SET: begin
                            n_chosen = i_node_index;
                            if ({1'b0, i_node_index} >= r_count) begin
                                n_err = wsts_pkg::ERR_INDEX;
                            end else begin
                                n_cur   = i_node_index;
                                n_state = ST_WRT;
                            end
                        end
                        wsts_pkg::ACT_SAMPLE: begin
                            if (r_root == '0) begin
                                n_err = wsts_pkg::ERR_ZERO;
                            end else begin
                                n_state = ST_M1;
                            end
                        end
                        default: begin
                            n_state = ST_DONE;
                        end
                    endcase
                end
            end
            ST_WRT: begin
                we_w    = 1'b1;
                n_first = 1'b1;
                n_state = ST_REF;
            end
            ST_REF: begin
                we_t      = 1'b1;
                n_first   = 1'b0;
                n_fwd_idx = r_cur;
                n_fwd     = step_out.sum;
                if (r_cur == '0) begin
                    n_root  = step_out.sum;
                    n_state = ST_DONE;
                end else begin
                    n_cur    = parent;
                    w_raddr  = parent;
                    ta_raddr = p_left[IW-1:0];
                    tb_raddr = p_right[IW-1:0];
                end
            end
            ST_M1: begin
                n_lo    = prod[wsts_pkg::PROD_W-1:FW];
                n_state = ST_M2;
            end
            ST_M2: begin
                n_hi    = prod[TW-1:0];
                n_state = ST_M3;
            end
            ST_M3: begin
                n_w      = (w_sum >= {1'b0, r_root}) ? r_root - TW'(1) : w_sum[TW-1:0];
                n_cur    = '0;
                w_raddr  = '0;
                ta_raddr = IW'(1);
                n_state  = ST_DESC;
            end
            ST_DESC: begin
                if (step_out.pick || (step_out.left && !l_pres)
                        || (!step_out.left && !rr_pres)) begin
                    n_chosen = r_cur;
                    n_state  = ST_DONE;
                end else begin
                    n_cur    = nxt;
                    n_w      = step_out.w_next;
                    w_raddr  = nxt;
                    ta_raddr = nxt_left[IW-1:0];
                end
            end
            ST_DONE: begin
                if (!r_ovalid || i_out_ready) begin
                    n_ovalid   = 1'b1;
                    n_o_chosen = r_chosen;
                    n_o_total  = r_root;
                    n_o_err    = r_err;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_count  <= '0;
            r_root   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_root   <= n_root;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur      <= n_cur;
        r_wt       <= n_wt;
        r_u        <= n_u;
        r_first    <= n_first;
        r_fwd_idx  <= n_fwd_idx;
        r_fwd      <= n_fwd;
        r_lo       <= n_lo;
        r_hi       <= n_hi;
        r_w        <= n_w;
        r_chosen   <= n_chosen;
        r_err      <= n_err;
        r_o_chosen <= n_o_chosen;
        r_o_total  <= n_o_total;
        r_o_err    <= n_o_err;
    end

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state != ST_IDLE))
        else $error("accepted item did not start work");

    a_node_present: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_REF) || (r_state == ST_DESC)) |-> ({1'b0, r_cur} < r_count))
        else $error("walk reached a node beyond the node count");

    a_point_below_root: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DESC) |-> (r_w < r_root))
        else $error("sample point not below root total");

    a_zero_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_error_code == wsts_pkg::ERR_ZERO)) |-> (o_total_weight == '0))
        else $error("zero-total error with nonzero total");

endmodule

`default_nettype wire

FILE: bench/tb_top.sv
// Testbench for weighted_sum_tree_sampler: drives append, set-weight, sample and
// unused-action items through the valid/ready channels and checks every result
// against a tree model. Depends on wsts_pkg and the weighted_sum_tree_sampler RTL.
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import wsts_pkg::*;

    localparam logic [1:0] ACT_UNUSED  = 2'd3;
    localparam int         CYCLE_LIMIT = 400000;
    localparam int         LONG_HOLD   = 300;

    typedef struct {
        bit [IDX_W-1:0] index;
        bit [TOT_W-1:0] total;
        bit [1:0]       err;
    } tree_result_t;

    class tree_tracker;
        bit [WEIGHT_BITS-1:0] node_wt [MAX_NODES];
        bit [TOT_W-1:0]       sub_tot [MAX_NODES];
        int unsigned          node_cnt;
        tree_result_t         expected_q[$];
        int unsigned          fail_count;

        function bit [TOT_W-1:0] total_at(int unsigned i);
            return (i < node_cnt) ? sub_tot[i] : '0;
        endfunction

        function bit [TOT_W-1:0] root_total();
            return (node_cnt != 0) ? sub_tot[0] : '0;
        endfunction

        function void refresh_path(int unsigned i);
            while (1) begin
                sub_tot[i] = TOT_W'(node_wt[i]) + total_at(2 * i + 1) + total_at(2 * i + 2);
                if (i == 0)
                    break;
                i = (i - 1) / 2;
            end
        endfunction

        function int unsigned descend_to(bit [63:0] w);
            int unsigned n;
            int unsigned l;
            int unsigned r;
            n = 0;
            while (n < node_cnt) begin
                l = 2 * n + 1;
                r = 2 * n + 2;
                if (w < node_wt[n])
                    return n;
                w -= node_wt[n];
                if (w < total_at(l)) begin
                    if (l >= node_cnt)
                        return n;
                    n = l;
                end else begin
                    w -= total_at(l);
                    if (r >= node_cnt)
                        return n;
                    n = r;
                end
            end
            return 0;
        endfunction

        function void note_item(logic [1:0] act, logic [IDX_W-1:0] idx,
                                logic [31:0] wt, logic [FRAC_W-1:0] u);
            tree_result_t    r;
            bit [TOT_W-1:0]  root;
            bit [63:0]       lo_prod;
            bit [63:0]       scaled;
            r.index = '0;
            r.err   = ERR_OK;
            case (act)
                ACT_APPEND: begin
                    if (node_cnt >= MAX_NODES) begin
                        r.err = ERR_FULL;
                    end else begin
                        node_wt[node_cnt] = wt;
                        r.index = IDX_W'(node_cnt);
                        node_cnt++;
                        refresh_path(node_cnt - 1);
                    end
                end
                ACT_SET: begin
                    r.index = idx;
                    if (idx >= node_cnt) begin
                        r.err = ERR_INDEX;
                    end else begin
                        node_wt[idx] = wt;
                        refresh_path(idx);
                    end
                end
                ACT_SAMPLE: begin
                    root = root_total();
                    if (root == 0) begin
                        r.err = ERR_ZERO;
                    end else begin
                        lo_prod = 64'(u) * 64'(root[31:0]);
                        scaled  = 64'(u) * 64'(root[TOT_W-1:32]) + 64'(lo_prod[63:32]);
                        if (scaled >= root)
                            scaled = root - 1;
                        r.index = IDX_W'(descend_to(scaled));
                    end
                end
                default: ;
            endcase
            r.total = root_total();
            expected_q.push_back(r);
        endfunction

        function void report_fail(string msg);
            fail_count++;
            if (fail_count <= 10)
                $display("%s", msg);
        endfunction

        function void check_result(logic [IDX_W-1:0] idx, logic [TOT_W-1:0] tot,
                                   logic [1:0] err);
            tree_result_t exp_r;
            if (expected_q.size() == 0) begin
                report_fail($sformatf("unexpected result: index %0d total %h error %0d",
                                      idx, tot, err));
                return;
            end
            exp_r = expected_q.pop_front();
            if (exp_r.index !== idx || exp_r.total !== tot || exp_r.err !== err)
                report_fail($sformatf(
                    "mismatch: expected index %0d total %h error %0d, got %0d %h %0d",
                    exp_r.index, exp_r.total, exp_r.err, idx, tot, err));
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_ready;
    logic [1:0]           i_action = '0;
    logic [IDX_W-1:0]     i_node_index = '0;
    logic [31:0]          i_weight = '0;
    logic [FRAC_W-1:0]    i_uniform_point = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    logic [IDX_W-1:0]     o_chosen_index;
    logic [TOT_W-1:0]     o_total_weight;
    logic [1:0]           o_error_code;

    tree_tracker tracker = new();
    bit          no_idle = 1'b0;
    bit          held_long = 1'b0;
    int unsigned results_seen = 0;
    int unsigned cycle_cnt = 0;

    weighted_sum_tree_sampler i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_action        (i_action),
        .i_node_index    (i_node_index),
        .i_weight        (i_weight),
        .i_uniform_point (i_uniform_point),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_chosen_index  (o_chosen_index),
        .o_total_weight  (o_total_weight),
        .o_error_code    (o_error_code)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            tracker.check_result(o_chosen_index, o_total_weight, o_error_code);
            results_seen++;
        end
    end

    function automatic logic [31:0] pick_weight();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2: return 32'($urandom_range(1, 255));
            3: return 32'h0001_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [FRAC_W-1:0] pick_point();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return $urandom;
        endcase
    endfunction

    task automatic drive_item(input logic [1:0] act, input logic [IDX_W-1:0] idx,
                              input logic [31:0] wt, input logic [FRAC_W-1:0] u);
        @(negedge i_clk);
        i_in_valid      <= 1'b1;
        i_action        <= act;
        i_node_index    <= idx;
        i_weight        <= wt;
        i_uniform_point <= u;
        do
            @(posedge i_clk);
        while (!o_in_ready);
        tracker.note_item(act, idx, wt, u);
    endtask

    task automatic sender_gap();
        if (!no_idle && $urandom_range(0, 4) == 0) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat ($urandom_range(0, 6)) @(negedge i_clk);
        end
    endtask

    task automatic random_item();
        int unsigned      pick;
        logic [IDX_W-1:0] idx;
        pick = $urandom_range(0, 99);
        idx  = IDX_W'($urandom);
        if (pick < 35)
            drive_item(ACT_APPEND, idx, pick_weight(), $urandom);
        else if (pick < 60 && tracker.node_cnt != 0)
            drive_item(ACT_SET, IDX_W'($urandom_range(0, tracker.node_cnt - 1)),
                       pick_weight(), $urandom);
        else if (pick < 68)
            drive_item(ACT_SET, idx, pick_weight(), $urandom);
        else if (pick < 96)
            drive_item(ACT_SAMPLE, idx, $urandom, pick_point());
        else
            drive_item(ACT_UNUSED, idx, $urandom, $urandom);
    endtask

    initial begin
        wait (i_rst_n);
        forever begin
            if (!held_long && results_seen >= 200) begin
                held_long = 1'b1;
                @(negedge i_clk);
                i_out_ready <= 1'b0;
                repeat (LONG_HOLD - 1) @(negedge i_clk);
            end else if (!no_idle && $urandom_range(0, 3) == 0) begin
                @(negedge i_clk);
                i_out_ready <= 1'b0;
                repeat ($urandom_range(0, 6)) @(negedge i_clk);
            end
            @(negedge i_clk);
            i_out_ready <= 1'b1;
        end
    end

    initial begin
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        drive_item(ACT_SAMPLE, '0, '0, $urandom);
        drive_item(ACT_SET, '0, '1, $urandom);
        drive_item(ACT_UNUSED, '1, '1, '1);
        drive_item(ACT_APPEND, '1, '0, '0);
        drive_item(ACT_SAMPLE, '0, '0, '1);
        drive_item(ACT_APPEND, '0, '0, $urandom);
        drive_item(ACT_SAMPLE, '0, '1, 32'h8000_0000);
        drive_item(ACT_SET, IDX_W'(1), '1, '0);
        drive_item(ACT_SAMPLE, '1, '0, '0);
        drive_item(ACT_SAMPLE, '0, '0, '1);
        drive_item(ACT_APPEND, '0, '1, '0);
        drive_item(ACT_APPEND, '0, 32'd1, '0);
        drive_item(ACT_APPEND, '0, 32'h0001_0000, '0);
        drive_item(ACT_SET, IDX_W'(5), 32'h1234_5678, '0);
        drive_item(ACT_SET, '1, '1, '1);
        drive_item(ACT_SET, IDX_W'(4), '0, '0);
        drive_item(ACT_SAMPLE, '0, '0, 32'h8000_0000);
        drive_item(ACT_SAMPLE, '0, '0, '1);
        drive_item(ACT_SAMPLE, '0, '0, 32'd1);
        drive_item(ACT_UNUSED, '0, '0, '0);
        drive_item(ACT_SET, '0, '1, '0);
        drive_item(ACT_SAMPLE, '1, '1, '1);

        for (int k = 0; k < 192; k++) begin
            no_idle = ((k / 64) % 3 == 2);
            sender_gap();
            random_item();
        end

        no_idle = 1'b0;
        while (tracker.node_cnt < MAX_NODES) begin
            sender_gap();
            if ($urandom_range(0, 7) == 0)
                drive_item(ACT_SAMPLE, IDX_W'($urandom), $urandom, pick_point());
            else
                drive_item(ACT_APPEND, IDX_W'($urandom), pick_weight(), $urandom);
        end

        no_idle = 1'b1;
        repeat (40) random_item();
        @(negedge i_clk);
        i_in_valid <= 1'b0;

        while (tracker.expected_q.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        if (tracker.fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

`default_nettype wire

FILE: weighted_sum_tree_sampler.f
rtl/wsts_pkg.sv
rtl/wsts_ram.sv
rtl/wsts_step.sv
rtl/weighted_sum_tree_sampler.sv
bench/tb_top.sv
